/* sv/bsfe_pkg.sv */
`timescale 1ns / 1ps

package bsfe_pkg;

  // Descriptor queue between the front and the back end.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Second byte of an escape pair.
  localparam logic [7:0] STUFF_FLAG_CODE = 8'h5E;
  localparam logic [7:0] STUFF_ESC_CODE  = 8'h5D;

  // Configuration register indexes.
  localparam logic [2:0] REG_FLAG     = 3'd0;
  localparam logic [2:0] REG_ESCAPE   = 3'd1;
  localparam logic [2:0] REG_ADDRESS  = 3'd2;
  localparam logic [2:0] REG_CTL_ZERO = 3'd3;
  localparam logic [2:0] REG_CTL_ONE  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_FLAG     = 8'h7E;
  localparam logic [7:0] RST_ESCAPE   = 8'h7D;
  localparam logic [7:0] RST_ADDRESS  = 8'h03;
  localparam logic [7:0] RST_CTL_ZERO = 8'h00;
  localparam logic [7:0] RST_CTL_ONE  = 8'h40;

  typedef enum logic [1:0] {
    STUFF_NONE = 2'd0,
    STUFF_FLAG = 2'd1,
    STUFF_ESC  = 2'd2
  } stuff_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] address_value;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  // One classified payload transfer, ready for the back end.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] ctl;
    logic [7:0] data;
    stuff_t     data_code;
    logic [7:0] chk;
    stuff_t     chk_code;
  } desc_t;

  // The flag test wins when flag and escape are equal.
  function automatic stuff_t classify(input logic [7:0] b, input logic [7:0] flag,
                                      input logic [7:0] esc);
    stuff_t code;
    if (b == flag) begin
      code = STUFF_FLAG;
    end else if (b == esc) begin
      code = STUFF_ESC;
    end else begin
      code = STUFF_NONE;
    end
    return code;
  endfunction

endpackage

/* sv/byte_stuffing_frame_encoder_top.sv */
`timescale 1ns / 1ps
// The first output byte of a payload transfer passes through the descriptor queue and the
// back-end output register before it appears on the outputs.
// Throughput: one output byte per cycle while out_ready is high, set by the back-end byte
// sequencer; a payload transfer produces 1 to 9 bytes (header 4, payload 1-2, check 1-2,
// closing flag 1). Acknowledge transfers produce no output.
// Reset (rst, synchronous, active high) restores the default configuration, clears the
// sequence bit, the running check and the descriptor queue.

module byte_stuffing_frame_encoder_top import bsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_end
);

  cfg_t  cfg;
  logic  q_full;
  logic  push;
  desc_t push_desc;
  logic  pop;
  logic  head_valid;
  desc_t head_desc;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value       <= RST_FLAG;
      cfg.escape_value     <= RST_ESCAPE;
      cfg.address_value    <= RST_ADDRESS;
      cfg.control_seq_zero <= RST_CTL_ZERO;
      cfg.control_seq_one  <= RST_CTL_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FLAG:     cfg.flag_value       <= cfg_data;
        REG_ESCAPE:   cfg.escape_value     <= cfg_data;
        REG_ADDRESS:  cfg.address_value    <= cfg_data;
        REG_CTL_ZERO: cfg.control_seq_zero <= cfg_data;
        REG_CTL_ONE:  cfg.control_seq_one  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bsfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  bsfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  bsfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

endmodule

/* sv/bsfe_front.sv */
`timescale 1ns / 1ps

module bsfe_front import bsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       push,
  output desc_t      push_desc
);

  logic       sequence_bit;
  logic [7:0] running_check;
  logic [7:0] chk_base;
  logic [7:0] chk_new;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && !cmd;

  // The check restarts on the opening byte of a frame.
  assign chk_base = first_byte ? 8'h00 : running_check;
  assign chk_new  = chk_base ^ data_byte;

  // Classify the payload and check bytes for stuffing.
  always_comb begin
    push_desc.first     = first_byte;
    push_desc.last      = last_byte;
    push_desc.ctl       = sequence_bit ? cfg.control_seq_one : cfg.control_seq_zero;
    push_desc.data      = data_byte;
    push_desc.data_code = classify(data_byte, cfg.flag_value, cfg.escape_value);
    push_desc.chk       = chk_new;
    push_desc.chk_code  = classify(chk_new, cfg.flag_value, cfg.escape_value);
  end

  // Sequence bit toggles on each accepted acknowledge; running check updates on each accepted payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_bit  <= 1'b0;
      running_check <= 8'h00;
    end else if (accept) begin
      if (cmd) begin
        sequence_bit <= !sequence_bit;
      end else begin
        running_check <= last_byte ? 8'h00 : chk_new;
      end
    end
  end

endmodule

/* sv/bsfe_queue.sv */
`timescale 1ns / 1ps

module bsfe_queue import bsfe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output desc_t head_desc
);

  desc_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_desc  = entries[rd_ptr];

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/bsfe_back.sv */
`timescale 1ns / 1ps

module bsfe_back import bsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  desc_t      head_desc,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_end
);

  typedef enum logic [9:0] {
    ST_BEGIN    = 10'b00_0000_0001,
    ST_HDR_FLAG = 10'b00_0000_0010,
    ST_HDR_ADDR = 10'b00_0000_0100,
    ST_HDR_CTL  = 10'b00_0000_1000,
    ST_HDR_XOR  = 10'b00_0001_0000,
    ST_DAT      = 10'b00_0010_0000,
    ST_DAT_ESC  = 10'b00_0100_0000,
    ST_CHK      = 10'b00_1000_0000,
    ST_CHK_ESC  = 10'b01_0000_0000,
    ST_CLOSE    = 10'b10_0000_0000
  } step_t;

  step_t      step;
  step_t      cur;
  step_t      step_next;
  logic       load;
  logic [7:0] byte_next;
  logic       done;
  logic       end_next;

  // The output register takes a new byte when it is empty or being drained.
  assign load = !out_valid || out_ready;
  assign pop  = load && head_valid && done;

  function automatic logic [7:0] second_code(input stuff_t code);
    return (code == STUFF_FLAG) ? STUFF_FLAG_CODE : STUFF_ESC_CODE;
  endfunction

  // Pick the byte for the current step and the step after it.
  always_comb begin
    cur       = (step == ST_BEGIN) ? (head_desc.first ? ST_HDR_FLAG : ST_DAT) : step;
    byte_next = 8'h00;
    step_next = ST_BEGIN;
    done      = 1'b0;
    end_next  = 1'b0;
    unique case (cur)
      ST_HDR_FLAG: begin
        byte_next = cfg.flag_value;
        step_next = ST_HDR_ADDR;
      end
      ST_HDR_ADDR: begin
        byte_next = cfg.address_value;
        step_next = ST_HDR_CTL;
      end
      ST_HDR_CTL: begin
        byte_next = head_desc.ctl;
        step_next = ST_HDR_XOR;
      end
      ST_HDR_XOR: begin
        byte_next = cfg.address_value ^ head_desc.ctl;
        step_next = ST_DAT;
      end
      ST_DAT: begin
        if (head_desc.data_code != STUFF_NONE) begin
          byte_next = cfg.escape_value;
          step_next = ST_DAT_ESC;
        end else begin
          byte_next = head_desc.data;
          step_next = head_desc.last ? ST_CHK : ST_BEGIN;
          done      = !head_desc.last;
        end
      end
      ST_DAT_ESC: begin
        byte_next = second_code(head_desc.data_code);
        step_next = head_desc.last ? ST_CHK : ST_BEGIN;
        done      = !head_desc.last;
      end
      ST_CHK: begin
        if (head_desc.chk_code != STUFF_NONE) begin
          byte_next = cfg.escape_value;
          step_next = ST_CHK_ESC;
        end else begin
          byte_next = head_desc.chk;
          step_next = ST_CLOSE;
        end
      end
      ST_CHK_ESC: begin
        byte_next = second_code(head_desc.chk_code);
        step_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_next = cfg.flag_value;
        step_next = ST_BEGIN;
        done      = 1'b1;
        end_next  = 1'b1;
      end
      default: begin
        step_next = ST_BEGIN;
      end
    endcase
  end

  // Step register advances once per byte handed to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_BEGIN;
    end else if (load && head_valid) begin
      step <= step_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte  <= byte_next;
      run_last  <= done;
      frame_end <= end_next;
    end
  end

  // The closing flag always ends the run of its transfer.
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last)
    else $error("closing flag not marked as last of its run");

  // A descriptor leaves the queue only as its final byte is loaded.
  a_pop_on_load: assert property (@(posedge clk) disable iff (rst)
    pop |-> load && head_valid && done)
    else $error("descriptor popped without loading its final byte");

  // With nothing queued the sequencer waits at the start of an item.
  a_idle_begin: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> step == ST_BEGIN)
    else $error("sequencer mid-item with an empty queue");

endmodule
